// ===== src/lbmeq_pkg.sv =====
// ---------------------------------------------------------------------------
// lbmeq_pkg
// Shared types, register codes and the D3Q19 lattice table for the
// equilibrium core.
// ---------------------------------------------------------------------------
`default_nettype none

package lbmeq_pkg;

   localparam int NUM_DIRECTIONS = 19;
   localparam int DIR_W          = 5;
   localparam int WGT_W          = 29;
   localparam int CU_W           = 34;   // signed c.u, |cu| <= 2^32
   localparam int U2_W           = 36;   // |u|^2 in Q.28
   localparam int CSR_DATA_W     = 32;

   localparam logic [DIR_W-1:0] LAST_DIR_FULL = 5'd18;
   localparam logic [DIR_W-1:0] LAST_DIR_HALF = 5'd17;

   localparam logic [WGT_W-1:0] WEIGHT_REST_RESET     = 29'd89478485;
   localparam logic [WGT_W-1:0] WEIGHT_AXIS_RESET     = 29'd14913081;
   localparam logic [WGT_W-1:0] WEIGHT_DIAGONAL_RESET = 29'd7456540;

   typedef enum logic [1:0] {
      REG_WEIGHT_REST     = 2'd0,
      REG_WEIGHT_AXIS     = 2'd1,
      REG_WEIGHT_DIAGONAL = 2'd2,
      REG_EQ_MODE         = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_FULL = 2'd0,
      MODE_SYM  = 2'd1,
      MODE_ANTI = 2'd2
   } eq_mode_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        density;
   } req_word_type;

   typedef struct packed {
      logic [DIR_W-1:0]   direction;
      logic signed [31:0] eq_value;
      logic               last_of_node;
   } rsp_word_type;

   // One direction handed from the sequencer to the datapath.
   typedef struct packed {
      logic                   valid;
      logic [DIR_W-1:0]       dir;
      logic                   last;
      logic [1:0]             mode;
      logic signed [CU_W-1:0] cu;
      logic [WGT_W-1:0]       weight;
      logic [30:0]            density;
      logic [U2_W-1:0]        u2;
   } issue_type;

   // Lattice vector of a direction: {x+, x-, y+, y-, z+, z-}.
   function automatic logic [5:0] dir_vec(input logic [DIR_W-1:0] d);
      logic [5:0] v;
      case (d)
         5'd1:    v = 6'b10_00_00;
         5'd2:    v = 6'b01_00_00;
         5'd3:    v = 6'b00_10_00;
         5'd4:    v = 6'b00_01_00;
         5'd5:    v = 6'b00_00_10;
         5'd6:    v = 6'b00_00_01;
         5'd7:    v = 6'b10_10_00;
         5'd8:    v = 6'b01_01_00;
         5'd9:    v = 6'b10_01_00;
         5'd10:   v = 6'b01_10_00;
         5'd11:   v = 6'b10_00_10;
         5'd12:   v = 6'b01_00_01;
         5'd13:   v = 6'b10_00_01;
         5'd14:   v = 6'b01_00_10;
         5'd15:   v = 6'b00_01_01;
         5'd16:   v = 6'b00_10_10;
         5'd17:   v = 6'b00_01_10;
         5'd18:   v = 6'b00_10_01;
         default: v = 6'b00_00_00;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/lbmeq_dir_pipe.sv =====
// ---------------------------------------------------------------------------
// lbmeq_dir_pipe
// Nine-stage datapath: one direction in per cycle, one population out.
// ---------------------------------------------------------------------------
`default_nettype none

module lbmeq_dir_pipe
   import lbmeq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire issue_type    iss,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word
);

   typedef struct packed {
      logic             valid;
      logic [DIR_W-1:0] dir;
      logic             last;
   } tag_type;

   // valid bits and tags per stage (index 2..9)
   tag_type tag_ff [2:9];
   tag_type tag_in [2:9];

   issue_type s1_ff;

   // stage 2
   logic [65:0]            cusq_ff;
   logic [59:0]            wrp_ff;
   logic signed [CU_W-1:0] cu2s_ff;
   logic [U2_W-1:0]        u2_2_ff;
   logic [1:0]             mode2_ff;
   // stage 3
   logic [37:0]            cu2_ff;
   logic [31:0]            wr3_ff;
   logic signed [CU_W-1:0] cu3_ff;
   logic [U2_W-1:0]        u2_3_ff;
   logic [1:0]             mode3_ff;
   // stage 4
   logic signed [42:0]     br_ff;
   logic [31:0]            wr4_ff;
   logic                   sh4_ff;
   // stage 5
   logic [41:0]            mag_ff;
   logic                   neg5_ff;
   logic [31:0]            wr5_ff;
   logic                   sh5_ff;
   // stage 6
   logic [63:0]            pplo_ff;
   logic [41:0]            pphi_ff;
   logic                   neg6_ff;
   logic                   sh6_ff;
   // stage 7
   logic [73:0]            prod_ff;
   logic                   neg7_ff;
   logic                   sh7_ff;
   // stage 8
   logic [46:0]            rnd_ff;
   logic                   neg8_ff;
   // stage 9
   logic signed [31:0]     val_ff;

   logic [32:0]            cu_mag;
   logic signed [42:0]     cu_x;
   logic signed [42:0]     cu2_x;
   logic signed [42:0]     u2_x;
   logic signed [42:0]     br_in;
   logic [46:0]            rnd_in;
   logic signed [31:0]     val_in;

   always_comb begin
      tag_in[2] = '{valid: s1_ff.valid, dir: s1_ff.dir, last: s1_ff.last};
      for (int i = 3; i <= 9; i++) begin
         tag_in[i] = tag_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         for (int i = 2; i <= 9; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         s1_ff.valid <= iss.valid;
         for (int i = 2; i <= 9; i++) begin
            tag_ff[i].valid <= tag_in[i].valid;
         end
      end
      s1_ff.dir     <= iss.dir;
      s1_ff.last    <= iss.last;
      s1_ff.mode    <= iss.mode;
      s1_ff.cu      <= iss.cu;
      s1_ff.weight  <= iss.weight;
      s1_ff.density <= iss.density;
      s1_ff.u2      <= iss.u2;
      for (int i = 2; i <= 9; i++) begin
         tag_ff[i].dir  <= tag_in[i].dir;
         tag_ff[i].last <= tag_in[i].last;
      end
   end

   // stage 2: square of c.u and w*rho
   assign cu_mag = s1_ff.cu[CU_W-1] ? 33'(-s1_ff.cu) : 33'(s1_ff.cu);

   always_ff @(posedge clock) begin
      cusq_ff  <= 66'(cu_mag) * 66'(cu_mag);
      wrp_ff   <= 60'(s1_ff.weight) * 60'(s1_ff.density);
      cu2s_ff  <= s1_ff.cu;
      u2_2_ff  <= s1_ff.u2;
      mode2_ff <= s1_ff.mode;
   end

   // stage 3: round both products half up
   always_ff @(posedge clock) begin
      cu2_ff   <= 38'((cusq_ff + (66'd1 << 27)) >> 28);
      wr3_ff   <= 32'((wrp_ff + (60'd1 << 27)) >> 28);
      cu3_ff   <= cu2s_ff;
      u2_3_ff  <= u2_2_ff;
      mode3_ff <= mode2_ff;
   end

   // stage 4: bracket term per mode
   always_comb begin
      cu_x  = 43'(cu3_ff);
      cu2_x = $signed({5'd0, cu2_ff});
      u2_x  = $signed({7'd0, u2_3_ff});
      if (mode3_ff == MODE_SYM) begin
         br_in = (43'sd1 <<< 29) - ((u2_x <<< 1) + u2_x) + ((cu2_x <<< 3) + cu2_x);
      end else if (mode3_ff == MODE_ANTI) begin
         br_in = (cu_x <<< 2) + (cu_x <<< 1);
      end else begin
         br_in = (43'sd1 <<< 29) + ((cu_x <<< 2) + (cu_x <<< 1))
               + ((cu2_x <<< 3) + cu2_x) - ((u2_x <<< 1) + u2_x);
      end
   end

   always_ff @(posedge clock) begin
      br_ff  <= br_in;
      wr4_ff <= wr3_ff;
      sh4_ff <= (mode3_ff != MODE_SYM) && (mode3_ff != MODE_ANTI);
   end

   // stage 5: sign and magnitude
   always_ff @(posedge clock) begin
      mag_ff  <= br_ff[42] ? 42'(-br_ff) : 42'(br_ff);
      neg5_ff <= br_ff[42];
      wr5_ff  <= wr4_ff;
      sh5_ff  <= sh4_ff;
   end

   // stage 6: two partial products
   always_ff @(posedge clock) begin
      pplo_ff <= 64'(mag_ff[31:0]) * 64'(wr5_ff);
      pphi_ff <= 42'(mag_ff[41:32]) * 42'(wr5_ff);
      neg6_ff <= neg5_ff;
      sh6_ff  <= sh5_ff;
   end

   // stage 7: combine partials
   always_ff @(posedge clock) begin
      prod_ff <= {pphi_ff, 32'd0} + 74'(pplo_ff);
      neg7_ff <= neg6_ff;
      sh7_ff  <= sh6_ff;
   end

   // stage 8: shift and round half away from zero on the magnitude
   assign rnd_in = sh7_ff ? 47'(prod_ff[73:29]) + 47'(prod_ff[28])
                          : 47'(prod_ff[73:28]) + 47'(prod_ff[27]);

   always_ff @(posedge clock) begin
      rnd_ff  <= rnd_in;
      neg8_ff <= neg7_ff;
   end

   // stage 9: saturate and apply sign
   always_comb begin
      if (!neg8_ff) begin
         val_in = (rnd_ff > 47'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rnd_ff[31:0]);
      end else begin
         val_in = (rnd_ff >= 47'h8000_0000) ? 32'sh8000_0000 : $signed(-rnd_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign rsp_valid             = tag_ff[9].valid;
   assign rsp_word.direction    = tag_ff[9].dir;
   assign rsp_word.eq_value     = val_ff;
   assign rsp_word.last_of_node = tag_ff[9].last;

endmodule

`default_nettype wire

// ===== src/lbm_d3q19_equilibrium_core.sv =====
// ---------------------------------------------------------------------------
// lbm_d3q19_equilibrium_core
// D3Q19 equilibrium populations of one lattice node, one direction a cycle.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive req_word (velocity and density of a node) with start high;
//   the word is taken at an edge where start is high and busy is low.
//   Output: one population per cycle on rsp_word, marked by the rsp_valid
//   strobe, in ascending direction order; last_of_node marks the final word.
//   Full mode gives 19 words (0..18), the symmetric and antisymmetric modes
//   give 10 words (0 and the odd directions).
//   Configuration: csr_valid/csr_ready/csr_index/csr_data write the three
//   weights and the mode; csr_ready is always high. Write only while idle.
// Path: a node passes the front end (capture, square, sum) and is loaded
//   into the direction sequencer; each direction then passes the
//   direction datapath of 9 stages.
// Flow: the direction sequencer issues one direction per cycle while a node
//   is loaded, in ascending order;
//   the next node waits in the front end while the current one is issued.
// Reset: weights and mode return to their defaults, all pipeline valid bits
//   clear. The receiver cannot stall: every word is strobed exactly once.
// ---------------------------------------------------------------------------
`default_nettype none

module lbm_d3q19_equilibrium_core
   import lbmeq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_word_type          req_word,
   // result channel
   output logic                       rsp_valid,
   output rsp_word_type               rsp_word,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [WGT_W-1:0] w_rest_ff;
   logic [WGT_W-1:0] w_axis_ff;
   logic [WGT_W-1:0] w_diag_ff;
   logic [1:0]       mode_ff;

   // front end: capture, square, sum
   logic            f1_v_ff;
   req_word_type    f1_word_ff;
   logic            f2_v_ff;
   req_word_type    f2_word_ff;
   logic [63:0]     sqx_ff, sqy_ff, sqz_ff;
   logic            f3_v_ff;
   req_word_type    f3_word_ff;
   logic [U2_W-1:0] f3_u2_ff;

   // direction sequencer
   logic             act_ff;
   logic [DIR_W-1:0] dir_ff;
   logic [DIR_W-1:0] dir_in;
   req_word_type     cur_word_ff;
   logic [U2_W-1:0]  cur_u2_ff;

   logic             accept;
   logic             halved;
   logic [DIR_W-1:0] last_dir;
   logic             at_last;
   logic             take;
   logic [31:0]      mag_x, mag_y, mag_z;
   logic [5:0]       vec;
   logic signed [CU_W-1:0] cu;
   issue_type        iss;

   assign csr_ready = 1'b1;
   assign busy      = f1_v_ff | f2_v_ff | f3_v_ff;
   assign accept    = start & ~busy;

   // hold configuration; write on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         w_rest_ff <= WEIGHT_REST_RESET;
         w_axis_ff <= WEIGHT_AXIS_RESET;
         w_diag_ff <= WEIGHT_DIAGONAL_RESET;
         mode_ff   <= MODE_FULL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WEIGHT_REST:     w_rest_ff <= csr_data[WGT_W-1:0];
            REG_WEIGHT_AXIS:     w_axis_ff <= csr_data[WGT_W-1:0];
            REG_WEIGHT_DIAGONAL: w_diag_ff <= csr_data[WGT_W-1:0];
            REG_EQ_MODE:         mode_ff   <= csr_data[1:0];
            default:             mode_ff   <= mode_ff;
         endcase
      end
   end

   // front end: one node at a time; the sum stage holds its node until taken
   assign mag_x = f1_word_ff.vel_x[31] ? 32'(-f1_word_ff.vel_x) : 32'(f1_word_ff.vel_x);
   assign mag_y = f1_word_ff.vel_y[31] ? 32'(-f1_word_ff.vel_y) : 32'(f1_word_ff.vel_y);
   assign mag_z = f1_word_ff.vel_z[31] ? 32'(-f1_word_ff.vel_z) : 32'(f1_word_ff.vel_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept;
         f2_v_ff <= f1_v_ff;
         if (f2_v_ff) begin
            f3_v_ff <= 1'b1;
         end else if (take) begin
            f3_v_ff <= 1'b0;
         end
      end
      if (accept) begin
         f1_word_ff <= req_word;
      end
      f2_word_ff <= f1_word_ff;
      sqx_ff     <= 64'(mag_x) * 64'(mag_x);
      sqy_ff     <= 64'(mag_y) * 64'(mag_y);
      sqz_ff     <= 64'(mag_z) * 64'(mag_z);
      if (f2_v_ff) begin
         f3_word_ff <= f2_word_ff;
         f3_u2_ff   <= 36'((sqx_ff + (64'd1 << 27)) >> 28)
                     + 36'((sqy_ff + (64'd1 << 27)) >> 28)
                     + 36'((sqz_ff + (64'd1 << 27)) >> 28);
      end
   end

   // sequencer: step through directions, reload from the front end
   assign halved   = (mode_ff == MODE_SYM) || (mode_ff == MODE_ANTI);
   assign last_dir = halved ? LAST_DIR_HALF : LAST_DIR_FULL;
   assign at_last  = (dir_ff == last_dir);
   assign take     = f3_v_ff & (~act_ff | at_last);

   always_comb begin
      if (halved && (dir_ff != '0)) begin
         dir_in = dir_ff + 5'd2;
      end else begin
         dir_in = dir_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (take) begin
         act_ff <= 1'b1;
      end else if (act_ff && at_last) begin
         act_ff <= 1'b0;
      end
      if (take) begin
         dir_ff      <= '0;
         cur_word_ff <= f3_word_ff;
         cur_u2_ff   <= f3_u2_ff;
      end else if (act_ff) begin
         dir_ff <= dir_in;
      end
   end

   // c.u for the current direction: add or drop each component
   always_comb begin
      vec = dir_vec(dir_ff);
      cu  = '0;
      if (vec[5]) cu = cu + CU_W'(cur_word_ff.vel_x);
      if (vec[4]) cu = cu - CU_W'(cur_word_ff.vel_x);
      if (vec[3]) cu = cu + CU_W'(cur_word_ff.vel_y);
      if (vec[2]) cu = cu - CU_W'(cur_word_ff.vel_y);
      if (vec[1]) cu = cu + CU_W'(cur_word_ff.vel_z);
      if (vec[0]) cu = cu - CU_W'(cur_word_ff.vel_z);

      iss.valid   = act_ff;
      iss.dir     = dir_ff;
      iss.last    = at_last;
      iss.mode    = mode_ff;
      iss.cu      = cu;
      iss.density = cur_word_ff.density;
      iss.u2      = cur_u2_ff;
      if (dir_ff == '0) begin
         iss.weight = w_rest_ff;
      end else if (dir_ff <= 5'd6) begin
         iss.weight = w_axis_ff;
      end else begin
         iss.weight = w_diag_ff;
      end
   end

   lbmeq_dir_pipe u_dir_pipe (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ===== verif/tb_lbm_d3q19_equilibrium_core.sv =====
// ---------------------------------------------------------------------------
// tb_lbm_d3q19_equilibrium_core
// Self-checking bench for the D3Q19 equilibrium core: node words go in
// through the start/busy handshake, and every population word that comes out
// is checked against a bit-exact fixed-point predictor kept in this module.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_lbm_d3q19_equilibrium_core
   import lbmeq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q28_ONE    = 64'd1 << 28;
   localparam int     DRAIN_WAIT = 40;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_word_type          req_word;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   lbm_d3q19_equilibrium_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Run-away guard: far above the slowest legal run.
   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end

   // Shadow copy of the configuration registers.
   logic [WGT_W-1:0] wgt_rest_q;
   logic [WGT_W-1:0] wgt_axis_q;
   logic [WGT_W-1:0] wgt_diag_q;
   logic [1:0]       mode_q;

   // Lattice vector components per direction.
   int lat_x [NUM_DIRECTIONS] = '{0,1,-1,0,0,0,0,1,-1,1,-1,1,-1,1,-1,0,0,0,0};
   int lat_y [NUM_DIRECTIONS] = '{0,0,0,1,-1,0,0,1,-1,-1,1,0,0,0,0,-1,1,-1,1};
   int lat_z [NUM_DIRECTIONS] = '{0,0,0,0,0,1,-1,0,0,0,0,1,-1,-1,1,-1,1,1,-1};

   rsp_word_type pending_pops[$];
   int           errors;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // round(m*m / 2^28), half up
   function automatic longint square_q28(input longint m);
      logic [127:0] p;
      p = 128'(m) * 128'(m) + (128'd1 << 27);
      return longint'(p >> 28);
   endfunction

   // round(b*wr / 2^s) half away from zero, clamped to the Q4.28 range
   function automatic logic signed [31:0] scale_clamp(input longint b, input longint wr,
                                                      input int s);
      logic [127:0] p;
      p = ((128'(magnitude(b)) * 128'(wr)) + (128'd1 << (s - 1))) >> s;
      if (b >= 0)
         return p > 128'h7FFF_FFFF ? 32'sh7FFF_FFFF : p[31:0];
      return p >= 128'h8000_0000 ? 32'sh8000_0000 : -p[31:0];
   endfunction

   // Work out every population word a node produces under the current setup.
   task automatic predict_node(input req_word_type w);
      longint vx, vy, vz, rho, u2, cu, cu2, wr, wgt, br;
      bit halved;
      int shift;
      rsp_word_type pop;
      vx = w.vel_x;
      vy = w.vel_y;
      vz = w.vel_z;
      rho = w.density;
      u2 = square_q28(magnitude(vx)) + square_q28(magnitude(vy)) + square_q28(magnitude(vz));
      halved = (mode_q == MODE_SYM) || (mode_q == MODE_ANTI);
      for (int d = 0; d < NUM_DIRECTIONS; d++) begin
         if (halved && d != 0 && d % 2 == 0)
            continue;
         wgt = d == 0 ? wgt_rest_q : (d <= 6 ? wgt_axis_q : wgt_diag_q);
         wr = (wgt * rho + (64'd1 << 27)) >> 28;
         cu = lat_x[d] * vx + lat_y[d] * vy + lat_z[d] * vz;
         cu2 = square_q28(magnitude(cu));
         if (mode_q == MODE_SYM) begin
            br = 2 * Q28_ONE - 3 * u2 + 9 * cu2;
            shift = 28;
         end else if (mode_q == MODE_ANTI) begin
            br = 6 * cu;
            shift = 28;
         end else begin
            br = 2 * Q28_ONE + 6 * cu + 9 * cu2 - 3 * u2;
            shift = 29;
         end
         pop.direction = d[DIR_W-1:0];
         pop.eq_value = scale_clamp(br, wr, shift);
         pop.last_of_node = (d == (halved ? LAST_DIR_HALF : LAST_DIR_FULL));
         pending_pops.push_back(pop);
      end
   endtask

   // Check each strobed population against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_pops.size() == 0) begin
            report_mismatch("unexpected word, direction", rsp_word.direction, -1);
         end else begin
            want = pending_pops.pop_front();
            if (rsp_word.direction !== want.direction)
               report_mismatch("direction", rsp_word.direction, want.direction);
            if (rsp_word.eq_value !== want.eq_value)
               report_mismatch("eq_value", rsp_word.eq_value, want.eq_value);
            if (rsp_word.last_of_node !== want.last_of_node)
               report_mismatch("last_of_node", rsp_word.last_of_node, want.last_of_node);
         end
      end
   end

   // Write one register, then mirror it in the shadow copy.
   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_WEIGHT_REST:     wgt_rest_q = data[WGT_W-1:0];
         REG_WEIGHT_AXIS:     wgt_axis_q = data[WGT_W-1:0];
         REG_WEIGHT_DIAGONAL: wgt_diag_q = data[WGT_W-1:0];
         REG_EQ_MODE:         mode_q     = data[1:0];
         default:             ;
      endcase
      @(posedge clock);
   endtask

   // Hold a node word on the bus until the core takes it, then predict.
   // A fixed value, where given, overrides the predictor for every direction.
   task automatic send_node(input req_word_type w, input bit calm, input bit has_fixed,
                            input logic signed [31:0] fixed_val);
      int gap;
      int first;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      first = pending_pops.size();
      predict_node(w);
      if (has_fixed)
         for (int i = first; i < pending_pops.size(); i++)
            pending_pops[i].eq_value = fixed_val;
      // Unless calm, idle after roughly a quarter of the nodes, gaps of varying length.
      gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(1, 30) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let the core drain before touching the registers.
   task automatic drain;
      start <= 1'b0;
      while (pending_pops.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_velocity;
      case ($urandom_range(5))
         0: return 32'($signed($urandom_range(0, 2 * 32'h1000_0000)) - 32'sh1000_0000);
         1: return 32'($signed($urandom_range(0, 2 * 32'h0400_0000)) - 32'sh0400_0000);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3: return 32'($signed($urandom_range(0, 2 * 32'h0010_0000)) - 32'sh0010_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_density;
      case ($urandom_range(4))
         0: return 31'($urandom_range(32'h1400_0000, 32'h0C00_0000));
         1: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_weight(input int phase);
      if (phase == 1) return '0;
      if (phase == 2) return 32'h1000_0000;
      // upper bits beyond the register width must be dropped by the core
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(0, 32'h1000_0000);
   endfunction

   typedef struct {
      logic [31:0] vx, vy, vz;
      logic [30:0] rho;
      bit          has_fixed;
      logic [31:0] fixed_val;
   } node_row_type;

   // Directed rows, default weights, full mode. Zero density zeroes everything.
   node_row_type node_table [] = '{
      '{32'h0,         32'h0,         32'h0,         31'd0,          1, 32'h0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0,          1, 32'h0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,          1, 32'h0},
      '{32'h0,         32'h0,         32'h0,         31'h1000_0000,  0, 32'h0},
      '{32'h1000_0000, 32'h0,         32'h0,         31'h1000_0000,  0, 32'h0},
      '{32'h0,         32'hF000_0000, 32'h0,         31'h1000_0000,  0, 32'h0},
      '{32'h0,         32'h0,         32'h1000_0000, 31'h1000_0000,  0, 32'h0},
      '{32'h0,         32'h0,         32'h0,         31'h7FFF_FFFF,  0, 32'h0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,  0, 32'h0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,  0, 32'h0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,  0, 32'h0},
      '{32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 31'h1100_0000,  0, 32'h0},
      '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 31'h0000_0001,  0, 32'h0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 31'h2AAA_AAAA,  0, 32'h0}
   };

   initial begin
      req_word_type w;
      bit calm;
      errors = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_WEIGHT_REST;
      csr_data  <= '0;
      wgt_rest_q = WEIGHT_REST_RESET;
      wgt_axis_q = WEIGHT_AXIS_RESET;
      wgt_diag_q = WEIGHT_DIAGONAL_RESET;
      mode_q     = MODE_FULL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset configuration.
      foreach (node_table[i]) begin
         w = '{node_table[i].vx, node_table[i].vy, node_table[i].vz, node_table[i].rho};
         send_node(w, 0, node_table[i].has_fixed, node_table[i].fixed_val);
      end

      // Random phases; each walks a new weight set and mode, mode 3 included.
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         write_reg(REG_WEIGHT_REST, rand_weight(phase));
         write_reg(REG_WEIGHT_AXIS, rand_weight(phase));
         write_reg(REG_WEIGHT_DIAGONAL, rand_weight(phase));
         write_reg(REG_EQ_MODE, CSR_DATA_W'(phase % 4));
         for (int n = 0; n < 45; n++) begin
            // send back to back, with no idle gaps, throughout phase 3
            calm = (phase == 3);
            w = '{rand_velocity(), rand_velocity(), rand_velocity(), rand_density()};
            send_node(w, calm, 0, '0);
         end
      end

      drain();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
